// File: rtl/core/breakable_spring_force_defines.svh
// Assertion macros for the checker file of the spring force block.
`ifndef BREAKABLE_SPRING_FORCE_DEFINES_SVH
`define BREAKABLE_SPRING_FORCE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define BSF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define BSF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/bsf_pkg.sv
// Shared types and constants of the breakable spring force block.
`default_nettype none

package bsf_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_RIGID_K   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGID_C   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGID_BRK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_K    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_C    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_BRK  = 3'd5;

    localparam logic [19:0] RST_RIGID_K   = 20'd50000;
    localparam logic [15:0] RST_RIGID_C   = 16'd500;
    localparam logic [23:0] RST_RIGID_BRK = 24'd32768;
    localparam logic [19:0] RST_SOFT_K    = 20'd5000;
    localparam logic [15:0] RST_SOFT_C    = 16'd200;
    localparam logic [23:0] RST_SOFT_BRK  = 24'd131072;

    // Outcome codes
    localparam logic [1:0] OUT_APPLIED = 2'd0;
    localparam logic [1:0] OUT_BROKE   = 2'd1;
    localparam logic [1:0] OUT_BROKEN  = 2'd2;
    localparam logic [1:0] OUT_ZERO    = 2'd3;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Shared divider
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 33;
    localparam int DIV_CNT_W = 6;

    // One classified item
    typedef struct packed {
        logic [7:0]  idx;
        logic        diag;
        logic [30:0] rest;
        logic [32:0] dx;
        logic [32:0] dy;
        logic [32:0] dvx;
        logic [32:0] dvy;
        logic [19:0] k;
        logic [15:0] c;
        logic [23:0] brk;
        logic        zero;
    } bsf_entry_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } bsf_div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } bsf_div_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_Y,
        ST_SQRT,
        ST_STR_GO,
        ST_STR_WAIT,
        ST_STR_CHK,
        ST_UX_GO,
        ST_UX_WAIT,
        ST_UY_GO,
        ST_UY_WAIT,
        ST_VX,
        ST_VY,
        ST_VR,
        ST_T,
        ST_FX_LO,
        ST_FX_HI,
        ST_FY_LO,
        ST_FY_HI,
        ST_FSAT,
        ST_DONE
    } bsf_state_t;

endpackage

`default_nettype wire

// File: rtl/core/bsf_front.sv
// Front end: configuration registers and classification of incoming items.
`default_nettype none

module bsf_front
    import bsf_pkg::*;
#(
    parameter int NUM_SPRINGS = 256
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [7:0]            spring_index,
    input  wire logic                  material_select,
    input  wire logic                  is_diagonal,
    input  wire logic [30:0]           rest_len,
    input  wire logic signed [31:0]    pos_a_x,
    input  wire logic signed [31:0]    pos_a_y,
    input  wire logic signed [31:0]    pos_b_x,
    input  wire logic signed [31:0]    pos_b_y,
    input  wire logic signed [31:0]    vel_a_x,
    input  wire logic signed [31:0]    vel_a_y,
    input  wire logic signed [31:0]    vel_b_x,
    input  wire logic signed [31:0]    vel_b_y,
    output bsf_entry_t                 entry
);

    localparam int MODN = (NUM_SPRINGS > 256) ? 256 : NUM_SPRINGS;
    localparam logic [15:0] MOD_N = 16'(MODN);

    logic [19:0] rigid_k_reg;
    logic [15:0] rigid_c_reg;
    logic [23:0] rigid_brk_reg;
    logic [19:0] soft_k_reg;
    logic [15:0] soft_c_reg;
    logic [23:0] soft_brk_reg;
    logic [15:0] idx_rem;
    logic [32:0] dx;
    logic [32:0] dy;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rigid_k_reg   <= RST_RIGID_K;
            rigid_c_reg   <= RST_RIGID_C;
            rigid_brk_reg <= RST_RIGID_BRK;
            soft_k_reg    <= RST_SOFT_K;
            soft_c_reg    <= RST_SOFT_C;
            soft_brk_reg  <= RST_SOFT_BRK;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_RIGID_K:   rigid_k_reg   <= cfg_data[19:0];
                REG_RIGID_C:   rigid_c_reg   <= cfg_data[15:0];
                REG_RIGID_BRK: rigid_brk_reg <= cfg_data;
                REG_SOFT_K:    soft_k_reg    <= cfg_data[19:0];
                REG_SOFT_C:    soft_c_reg    <= cfg_data[15:0];
                REG_SOFT_BRK:  soft_brk_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Spring index modulo the table size, restoring style over eight bits
    always_comb
    begin
        idx_rem = {8'd0, spring_index};
        for (int b = 7; b >= 0; b--)
        begin
            if (idx_rem >= (MOD_N << b))
                idx_rem = idx_rem - (MOD_N << b);
        end
    end

    assign dx = {pos_b_x[31], pos_b_x} - {pos_a_x[31], pos_a_x};
    assign dy = {pos_b_y[31], pos_b_y} - {pos_a_y[31], pos_a_y};

    // Classified item
    always_comb
    begin
        entry.idx  = idx_rem[7:0];
        entry.diag = is_diagonal;
        entry.rest = (rest_len == 31'd0) ? 31'd1 : rest_len;
        entry.dx   = dx;
        entry.dy   = dy;
        entry.dvx  = {vel_b_x[31], vel_b_x} - {vel_a_x[31], vel_a_x};
        entry.dvy  = {vel_b_y[31], vel_b_y} - {vel_a_y[31], vel_a_y};
        entry.k    = material_select ? soft_k_reg   : rigid_k_reg;
        entry.c    = material_select ? soft_c_reg   : rigid_c_reg;
        entry.brk  = material_select ? soft_brk_reg : rigid_brk_reg;
        entry.zero = (dx == 33'd0) && (dy == 33'd0);
    end

endmodule

`default_nettype wire

// File: rtl/core/bsf_queue.sv
// Short item queue between the front end and the force engine.
`default_nettype none

module bsf_queue
    import bsf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  bsf_entry_t       wdata,
    output logic             full,
    input  wire logic        pop,
    output bsf_entry_t       rdata,
    output logic             empty
);

    bsf_entry_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bsf_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module bsf_div
    import bsf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  bsf_div_req_t req,
    output bsf_div_rsp_t rsp
);

    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   rem_sh;
    logic                 ge;

    assign rem_sh = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign ge     = (rem_sh >= {1'b0, den_reg});

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            num_reg <= {num_reg[DIV_NUM_W-2:0], 1'b0};
            rem_reg <= ge ? DIV_DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DIV_DEN_W-1:0];
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], ge};
        end
    end

    // Step counter and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bsf_back.sv
// Force engine: broken flags, length, strain, direction and damped force.
`default_nettype none

module bsf_back
    import bsf_pkg::*;
#(
    parameter int NUM_SPRINGS = 256
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  bsf_entry_t        head,
    input  wire logic         q_empty,
    output logic              q_pop,
    output logic              empty,
    input  wire logic         pop,
    output logic signed [47:0] force_x,
    output logic signed [47:0] force_y,
    output logic signed [23:0] strain,
    output logic [1:0]        outcome
);

    localparam int FLAG_N = (NUM_SPRINGS > 256) ? 256 : NUM_SPRINGS;
    localparam int FLAG_W = (FLAG_N > 1) ? $clog2(FLAG_N) : 1;

    bsf_state_t          state_reg;
    bsf_state_t          state_next;
    logic [FLAG_N-1:0]   flag_reg;
    bsf_entry_t          e_reg;
    logic [65:0]         sum_reg;
    logic [65:0]         rad_reg;
    logic [34:0]         rem_reg;
    logic [32:0]         root_reg;
    logic [5:0]          cnt_reg;
    logic signed [31:0]  ux_reg;
    logic signed [31:0]  uy_reg;
    logic [65:0]         acc_reg;
    logic signed [35:0]  vr_reg;
    logic signed [54:0]  sp_reg;
    logic signed [55:0]  t_reg;
    logic [58:0]         pp_reg;
    logic [86:0]         prod_reg;
    logic [47:0]         res_fx_reg;
    logic [47:0]         res_fy_reg;
    logic [23:0]         res_strain_reg;
    logic [1:0]          res_outcome_reg;
    logic                out_valid_reg;
    logic [47:0]         out_fx_reg;
    logic [47:0]         out_fy_reg;
    logic [23:0]         out_strain_reg;
    logic [1:0]          out_outcome_reg;

    bsf_div_req_t        div_req;
    bsf_div_rsp_t        div_rsp;
    logic                out_load;

    logic                head_flag;
    logic [32:0]         head_adx;
    logic [32:0]         e_ady;
    logic [32:0]         e_adx;
    logic [36:0]         rem_sh;
    logic [36:0]         trial;
    logic                sq_ge;
    logic signed [33:0]  ext_s;
    logic [33:0]         ext_mag;
    logic [DIV_NUM_W-1:0] quo;
    logic                brk_hit;
    logic [23:0]         strain_sat;
    logic [31:0]         uq;
    logic signed [64:0]  pv;
    logic                vr_rnd;
    logic signed [54:0]  sp_prod;
    logic signed [54:0]  sp_adj;
    logic signed [54:0]  sp_half;
    logic signed [52:0]  cv;
    logic signed [31:0]  u_sel;
    logic [31:0]         mu32;
    logic [30:0]         mu;
    logic [55:0]         mt;
    logic [58:0]         pp_hi;
    logic                f_neg;

    // Saturate |T*u| >> 30 with its sign into the 48-bit force range
    function automatic logic [47:0] force_sat(input logic [86:0] p, input logic neg);
        logic [56:0] m;
        logic [47:0] r;
        m = p[86:30];
        if (neg)
            r = (m >= 57'h0800000000000) ? 48'h800000000000 : 48'd0 - m[47:0];
        else
            r = (m > 57'h07FFFFFFFFFFF) ? 48'h7FFFFFFFFFFF : m[47:0];
        return r;
    endfunction

    bsf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Operand shaping
    assign head_flag = flag_reg[head.idx[FLAG_W-1:0]];
    assign head_adx  = head.dx[32] ? 33'd0 - head.dx : head.dx;
    assign e_adx     = e_reg.dx[32] ? 33'd0 - e_reg.dx : e_reg.dx;
    assign e_ady     = e_reg.dy[32] ? 33'd0 - e_reg.dy : e_reg.dy;

    // One square-root digit
    assign rem_sh = {rem_reg, rad_reg[65:64]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign sq_ge  = (rem_sh >= trial);

    // Extension and strain
    assign ext_s   = $signed({1'b0, root_reg}) - $signed({3'b000, e_reg.rest});
    assign ext_mag = ext_s[33] ? 34'd0 - ext_s : ext_s;
    assign quo     = div_rsp.quo;
    assign brk_hit = (quo > {40'd0, e_reg.brk});

    always_comb
    begin
        if (ext_s[33])
            strain_sat = (quo > 64'h800000) ? 24'h800000 : 24'd0 - quo[23:0];
        else
            strain_sat = (quo > 64'h7FFFFF) ? 24'h7FFFFF : quo[23:0];
    end

    // Direction component from the quotient, signed by the axis offset
    assign uq = {1'b0, quo[30:0]};

    // Relative velocity projection, spring and damping parts
    assign pv      = (state_reg == ST_VX) ? $signed(e_reg.dvx) * ux_reg
                                          : $signed(e_reg.dvy) * uy_reg;
    assign vr_rnd  = acc_reg[65] && (acc_reg[29:0] != 30'd0);
    assign sp_prod = $signed({1'b0, e_reg.k}) * ext_s;
    assign sp_adj  = sp_reg + $signed({54'd0, sp_reg[54] & e_reg.diag});
    assign sp_half = e_reg.diag ? (sp_adj >>> 1) : sp_reg;
    assign cv      = $signed({1'b0, e_reg.c}) * vr_reg;

    // Force scaling in two partial products per axis
    assign u_sel = ((state_reg == ST_FX_LO) || (state_reg == ST_FX_HI)) ? ux_reg : uy_reg;
    assign mu32  = u_sel[31] ? 32'd0 - u_sel : u_sel;
    assign mu    = mu32[30:0];
    assign mt    = t_reg[55] ? 56'd0 - t_reg : t_reg;
    assign pp_hi = mt[55:28] * mu;
    assign f_neg = t_reg[55] ^ u_sel[31];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    if (head_flag || head.zero)
                        state_next = ST_DONE;
                    else
                        state_next = ST_SQ_Y;
                end
            end
            ST_SQ_Y:     state_next = ST_SQRT;
            ST_SQRT:     state_next = (cnt_reg == 6'd32) ? ST_STR_GO : ST_SQRT;
            ST_STR_GO:   state_next = ST_STR_WAIT;
            ST_STR_WAIT: state_next = div_rsp.done ? ST_STR_CHK : ST_STR_WAIT;
            ST_STR_CHK:  state_next = brk_hit ? ST_DONE : ST_UX_GO;
            ST_UX_GO:    state_next = ST_UX_WAIT;
            ST_UX_WAIT:  state_next = div_rsp.done ? ST_UY_GO : ST_UX_WAIT;
            ST_UY_GO:    state_next = ST_UY_WAIT;
            ST_UY_WAIT:  state_next = div_rsp.done ? ST_VX : ST_UY_WAIT;
            ST_VX:       state_next = ST_VY;
            ST_VY:       state_next = ST_VR;
            ST_VR:       state_next = ST_T;
            ST_T:        state_next = ST_FX_LO;
            ST_FX_LO:    state_next = ST_FX_HI;
            ST_FX_HI:    state_next = ST_FY_LO;
            ST_FY_LO:    state_next = ST_FY_HI;
            ST_FY_HI:    state_next = ST_FSAT;
            ST_FSAT:     state_next = ST_DONE;
            ST_DONE:     state_next = (!out_valid_reg || pop) ? ST_IDLE : ST_DONE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        q_pop         = 1'b0;
        out_load      = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = {15'd0, ext_mag[32:0], 16'd0};
        div_req.den   = {2'b00, e_reg.rest};
        case (state_reg)
            ST_IDLE:   q_pop = !q_empty;
            ST_STR_GO: div_req.start = 1'b1;
            ST_UX_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = {1'b0, e_adx, 30'd0};
                div_req.den   = root_reg;
            end
            ST_UY_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = {1'b0, e_ady, 30'd0};
                div_req.den   = root_reg;
            end
            ST_DONE:   out_load = !out_valid_reg || pop;
            default:   ;
        endcase
    end

    // State and broken flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            flag_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_STR_CHK) && brk_hit)
                flag_reg[e_reg.idx[FLAG_W-1:0]] <= 1'b1;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                e_reg          <= head;
                sum_reg        <= head_adx * head_adx;
                res_fx_reg     <= '0;
                res_fy_reg     <= '0;
                res_strain_reg <= '0;
                res_outcome_reg <= head_flag ? OUT_BROKEN
                                 : (head.zero ? OUT_ZERO : OUT_APPLIED);
            end
            ST_SQ_Y:
            begin
                rad_reg  <= sum_reg + e_ady * e_ady;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            ST_SQRT:
            begin
                rem_reg  <= sq_ge ? 35'(rem_sh - trial) : rem_sh[34:0];
                root_reg <= {root_reg[31:0], sq_ge};
                rad_reg  <= {rad_reg[63:0], 2'b00};
                cnt_reg  <= cnt_reg + 1'b1;
            end
            ST_STR_CHK:
            begin
                res_strain_reg <= strain_sat;
                if (brk_hit)
                    res_outcome_reg <= OUT_BROKE;
            end
            ST_UY_GO: ux_reg <= e_reg.dx[32] ? 32'd0 - uq : uq;
            ST_VX:
            begin
                uy_reg  <= e_reg.dy[32] ? 32'd0 - uq : uq;
                acc_reg <= {pv[64], pv};
            end
            ST_VY: acc_reg <= acc_reg + {pv[64], pv};
            ST_VR:
            begin
                vr_reg <= acc_reg[65:30] + {35'd0, vr_rnd};
                sp_reg <= sp_prod;
            end
            ST_T:     t_reg <= 56'(sp_half) + 56'(cv);
            ST_FX_LO: pp_reg <= mt[27:0] * mu;
            ST_FX_HI: prod_reg <= {28'd0, pp_reg} + {pp_hi, 28'd0};
            ST_FY_LO:
            begin
                res_fx_reg <= force_sat(prod_reg, t_reg[55] ^ ux_reg[31]);
                pp_reg     <= mt[27:0] * mu;
            end
            ST_FY_HI: prod_reg <= {28'd0, pp_reg} + {pp_hi, 28'd0};
            ST_FSAT:  res_fy_reg <= force_sat(prod_reg, f_neg);
            default:  ;
        endcase
    end

    // Result register toward the consumer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_fx_reg      <= res_fx_reg;
            out_fy_reg      <= res_fy_reg;
            out_strain_reg  <= res_strain_reg;
            out_outcome_reg <= res_outcome_reg;
        end
    end

    assign empty   = !out_valid_reg;
    assign force_x = out_fx_reg;
    assign force_y = out_fy_reg;
    assign strain  = out_strain_reg;
    assign outcome = out_outcome_reg;

endmodule

`default_nettype wire

// File: rtl/core/breakable_spring_force.sv
// Top level of the breakable damped spring force evaluator.
//
//   channel   handshake            payload
//   --------  -------------------  ------------------------------------------
//   input     push / full          spring_index .. vel_b_y
//   result    empty / pop          force_x, force_y, strain, outcome
//   config    cfg_write            cfg_index, cfg_data
//
// Paths through the engine: an already broken or zero-distance spring skips
// the computation; a spring that breaks ends after the strain check; a force
// result runs the 33-digit square root and the 64-step shared divider, used
// once for strain and once per direction axis.
// Up to four items wait in the queue while the engine works.
// Reset clears the broken flags, the queue and the result register.
// A waiting result stalls the engine only; the front accepts items until the
// queue fills.
`default_nettype none

module breakable_spring_force
    import bsf_pkg::*;
#(
    parameter int NUM_SPRINGS = 256
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [7:0]            spring_index,
    input  wire logic                  material_select,
    input  wire logic                  is_diagonal,
    input  wire logic [30:0]           rest_len,
    input  wire logic signed [31:0]    pos_a_x,
    input  wire logic signed [31:0]    pos_a_y,
    input  wire logic signed [31:0]    pos_b_x,
    input  wire logic signed [31:0]    pos_b_y,
    input  wire logic signed [31:0]    vel_a_x,
    input  wire logic signed [31:0]    vel_a_y,
    input  wire logic signed [31:0]    vel_b_x,
    input  wire logic signed [31:0]    vel_b_y,
    output logic                       empty,
    input  wire logic                  pop,
    output logic signed [47:0]         force_x,
    output logic signed [47:0]         force_y,
    output logic signed [23:0]         strain,
    output logic [1:0]                 outcome
);

    bsf_entry_t entry;
    bsf_entry_t head;
    logic       q_empty;
    logic       q_pop;

    bsf_front #(
        .NUM_SPRINGS (NUM_SPRINGS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .spring_index    (spring_index),
        .material_select (material_select),
        .is_diagonal     (is_diagonal),
        .rest_len        (rest_len),
        .pos_a_x         (pos_a_x),
        .pos_a_y         (pos_a_y),
        .pos_b_x         (pos_b_x),
        .pos_b_y         (pos_b_y),
        .vel_a_x         (vel_a_x),
        .vel_a_y         (vel_a_y),
        .vel_b_x         (vel_b_x),
        .vel_b_y         (vel_b_y),
        .entry           (entry)
    );

    bsf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (entry),
        .full  (full),
        .pop   (q_pop),
        .rdata (head),
        .empty (q_empty)
    );

    bsf_back #(
        .NUM_SPRINGS (NUM_SPRINGS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .force_x (force_x),
        .force_y (force_y),
        .strain  (strain),
        .outcome (outcome)
    );

endmodule

`default_nettype wire

// File: rtl/core/bsf_checker.sv
// Port-level checks of the spring force block, bound to its top level.
`default_nettype none
`include "breakable_spring_force_defines.svh"

module bsf_checker
    import bsf_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              empty,
    input wire logic              pop,
    input wire logic signed [47:0] force_x,
    input wire logic signed [47:0] force_y,
    input wire logic signed [23:0] strain,
    input wire logic [1:0]        outcome
);

    // A waiting result holds until taken
    `BSF_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(force_x) && $stable(force_y) && $stable(strain) && $stable(outcome), "result changed while waiting")

    // No computation for broken or degenerate springs
    `BSF_ASSERT_NOW(a_skip_all_zero, !empty && (outcome == OUT_BROKEN || outcome == OUT_ZERO), force_x == 48'sd0 && force_y == 48'sd0 && strain == 24'sd0, "skipped spring with nonzero fields")

    // A fresh break carries no force but a nonzero strain
    `BSF_ASSERT_NOW(a_break_fields, !empty && outcome == OUT_BROKE, force_x == 48'sd0 && force_y == 48'sd0 && strain != 24'sd0, "break result fields wrong")

endmodule

bind breakable_spring_force bsf_checker u_bsf_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .empty   (empty),
    .pop     (pop),
    .force_x (force_x),
    .force_y (force_y),
    .strain  (strain),
    .outcome (outcome)
);

`default_nettype wire
